// ===== sv/pcdrc_pkg.sv =====
// Shared types and constants for the page checksum dirty range coalescer.
// No dependencies; every other file refers to this package by scoped names.
package pcdrc_pkg;

  localparam int PAGE_W        = 10;
  localparam int SUM_W         = 32;
  localparam int PB_W          = 17;
  localparam int RB_W          = 27;
  localparam int PC_W          = 11;
  localparam int OFF_W         = 26;
  localparam int SIZE_W        = 27;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 27;
  localparam int MAX_PAGES_DEF = 1024;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [PB_W-1:0] PAGE_BYTES_RST   = 17'd4096;
  localparam logic [RB_W-1:0] REGION_BYTES_RST = 27'd4096;
  localparam logic [PC_W-1:0] PAGE_COUNT_RST   = 11'd1;

  typedef enum logic {
    CMD_INIT = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_BYTES   = 2'd0,
    CFG_REGION_BYTES = 2'd1,
    CFG_PAGE_COUNT   = 2'd2
  } cfg_reg_t;

  // classified word handed from the front to the back
  typedef struct packed {
    cmd_t              cmd;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] slot;
    logic [SUM_W-1:0]  chksum;
    logic              last;
  } entry_t;

endpackage

// ===== sv/pcdrc_item_if.sv =====
// Input channel: one page checksum word with its page number and command.
// Depends on pcdrc_pkg for field widths.
interface pcdrc_item_if;
  logic                            valid;
  logic                            ready;
  logic                            command;
  logic [pcdrc_pkg::PAGE_W-1:0]    page_num;
  logic [pcdrc_pkg::SUM_W-1:0]     page_checksum;

  modport source (output valid, command, page_num, page_checksum, input ready);
  modport sink   (input valid, command, page_num, page_checksum, output ready);
endinterface

// ===== sv/pcdrc_result_if.sv =====
// Output channel: one dirty run as byte offset and byte length.
// Depends on pcdrc_pkg for field widths.
interface pcdrc_result_if;
  logic                          valid;
  logic                          ready;
  logic [pcdrc_pkg::OFF_W-1:0]   run_offset;
  logic [pcdrc_pkg::SIZE_W-1:0]  run_len;

  modport source (output valid, run_offset, run_len, input ready);
  modport sink   (input valid, run_offset, run_len, output ready);
endinterface

// ===== sv/pcdrc_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on pcdrc_pkg for field widths.
interface pcdrc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcdrc_pkg::CFG_IDX_W-1:0]   index;
  logic [pcdrc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/pcdrc_front.sv =====
// Front stage: accepts input words, flags the last page and reduces the page
// index to a table slot. Depends on pcdrc_pkg and pcdrc_item_if.
module pcdrc_front #(
  parameter int MAX_PAGES = pcdrc_pkg::MAX_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  pcdrc_item_if.sink                    item,
  input  logic [pcdrc_pkg::PC_W-1:0]    page_count,
  output pcdrc_pkg::entry_t             ent,
  output logic                          ent_valid,
  input  logic                          ent_ready
);

  // slot = page mod MAX_PAGES: reciprocal estimate (low by at most one), then one fix-up
  localparam int RECIP_SH = 2 * pcdrc_pkg::PAGE_W;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int QP_W     = pcdrc_pkg::PAGE_W + RECIP_W;
  localparam int MOD_W    = 17;
  localparam int QM_W     = pcdrc_pkg::PAGE_W + MOD_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH) / MAX_PAGES);
  localparam logic [MOD_W-1:0]   MOD   = MOD_W'(MAX_PAGES);

  logic                               f_valid;
  pcdrc_pkg::cmd_t                    f_cmd;
  logic [pcdrc_pkg::PAGE_W-1:0]       f_page;
  logic [pcdrc_pkg::SUM_W-1:0]        f_sum;
  logic                               f_last;
  logic [pcdrc_pkg::PAGE_W-1:0]       f_q;

  logic [QP_W-1:0]                    qprod;
  logic                               last_in;
  logic [QM_W-1:0]                    qm;
  logic [QM_W-1:0]                    diff;
  logic [pcdrc_pkg::PAGE_W-1:0]       r0;
  logic [MOD_W-1:0]                   r1;
  logic [pcdrc_pkg::PAGE_W-1:0]       slot;

  assign item.ready = !f_valid || ent_ready;

  assign qprod   = QP_W'(item.page_num) * QP_W'(RECIP);
  assign last_in = (page_count != '0) &&
                   ({1'b0, item.page_num} == page_count - 11'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (item.ready) begin
      f_valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      f_cmd  <= pcdrc_pkg::cmd_t'(item.command);
      f_page <= item.page_num;
      f_sum  <= item.page_checksum;
      f_last <= last_in;
      f_q    <= qprod[RECIP_SH +: pcdrc_pkg::PAGE_W];
    end
  end

  assign qm   = QM_W'(f_q) * QM_W'(MOD);
  assign diff = QM_W'(f_page) - qm;
  assign r0   = diff[pcdrc_pkg::PAGE_W-1:0];
  assign r1   = MOD_W'(r0) - MOD;
  assign slot = (MOD_W'(r0) >= MOD) ? r1[pcdrc_pkg::PAGE_W-1:0] : r0;

  assign ent_valid  = f_valid;
  assign ent.cmd    = f_cmd;
  assign ent.page   = f_page;
  assign ent.slot   = slot;
  assign ent.chksum = f_sum;
  assign ent.last   = f_last;

endmodule

// ===== sv/pcdrc_queue.sv =====
// Short FIFO of classified words between the front and the back.
// Depends on pcdrc_pkg.
module pcdrc_queue (
  input  logic               clk,
  input  logic               rst,
  input  pcdrc_pkg::entry_t  push_data,
  input  logic               push_valid,
  output logic               push_ready,
  output pcdrc_pkg::entry_t  head,
  output logic               head_valid,
  input  logic               pop
);

  localparam int DEPTH = pcdrc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  pcdrc_pkg::entry_t   entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                push;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign push       = push_valid && push_ready;
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== sv/pcdrc_back.sv =====
// Back end: checksum table read-modify-write, run tracking, offset/size
// multiply and the result register. Depends on pcdrc_pkg and pcdrc_result_if.
module pcdrc_back #(
  parameter int MAX_PAGES = pcdrc_pkg::MAX_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pcdrc_pkg::entry_t             head,
  input  logic                          head_valid,
  output logic                          pop,
  input  logic [pcdrc_pkg::PB_W-1:0]    page_bytes,
  input  logic [pcdrc_pkg::RB_W-1:0]    region_bytes,
  pcdrc_result_if.source                result
);

  localparam int SLOT_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int MUL_W  = pcdrc_pkg::PAGE_W + pcdrc_pkg::PB_W;

  logic [pcdrc_pkg::SUM_W-1:0]    mem [MAX_PAGES];
  logic                           adv;

  // execute stage
  logic                           b1_valid;
  pcdrc_pkg::entry_t              b1;
  logic [pcdrc_pkg::SUM_W-1:0]    rdata;
  logic                           fwd;
  logic [pcdrc_pkg::SUM_W-1:0]    fwd_sum;
  logic [pcdrc_pkg::SUM_W-1:0]    stored;

  logic                           run_open;
  logic [pcdrc_pkg::PAGE_W-1:0]   run_start;
  logic                           run_open_next;
  logic [pcdrc_pkg::PAGE_W-1:0]   run_start_next;
  logic                           emit;
  logic                           emit_trail;
  logic [pcdrc_pkg::PAGE_W-1:0]   emit_start;
  logic [pcdrc_pkg::PAGE_W-1:0]   emit_pages;

  // multiply stage
  logic                           b2_valid;
  logic                           b2_trail;
  logic [pcdrc_pkg::PAGE_W-1:0]   b2_start;
  logic [pcdrc_pkg::PAGE_W-1:0]   b2_pages;
  logic [MUL_W-1:0]               prod_off;
  logic [MUL_W-1:0]               prod_size;

  // size stage
  logic                           b3_valid;
  logic                           b3_trail;
  logic [pcdrc_pkg::OFF_W-1:0]    b3_off;
  logic [pcdrc_pkg::SIZE_W-1:0]   b3_prod;

  logic                           out_valid;
  logic [pcdrc_pkg::OFF_W-1:0]    out_offset;
  logic [pcdrc_pkg::SIZE_W-1:0]   out_size;

  assign adv = !out_valid || result.ready;
  assign pop = adv && head_valid;

  // table: read for the incoming word while the executing word writes back
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata <= mem[SLOT_W'(head.slot)];
      if (b1_valid) begin
        mem[SLOT_W'(b1.slot)] <= b1.chksum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else if (adv) begin
      b1_valid <= head_valid;
      fwd      <= b1_valid && head_valid && (b1.slot == head.slot);
    end
    if (adv) begin
      b1      <= head;
      fwd_sum <= b1.chksum;
    end
  end

  assign stored = fwd ? fwd_sum : rdata;

  always_comb begin
    run_open_next  = run_open;
    run_start_next = run_start;
    emit           = 1'b0;
    emit_trail     = 1'b0;
    emit_start     = run_start;
    emit_pages     = b1.page - run_start;
    unique case (b1.cmd)
      pcdrc_pkg::CMD_INIT: begin
        run_open_next = 1'b0;
      end
      pcdrc_pkg::CMD_SCAN: begin
        if (b1.chksum != stored) begin
          if (!run_open) begin
            run_open_next  = 1'b1;
            run_start_next = b1.page;
          end
        end else if (run_open) begin
          emit          = 1'b1;
          run_open_next = 1'b0;
        end
        // trailing run at the last page, measured to the region end
        if (!emit && run_open_next && b1.last) begin
          emit          = 1'b1;
          emit_trail    = 1'b1;
          emit_start    = run_start_next;
          run_open_next = 1'b0;
        end
      end
      default: begin
        run_open_next = run_open;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open  <= 1'b0;
      run_start <= '0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (b1_valid) begin
        run_open  <= run_open_next;
        run_start <= run_start_next;
      end
      b2_valid  <= b1_valid && emit;
      b3_valid  <= b2_valid;
      out_valid <= b3_valid;
    end
  end

  assign prod_off  = MUL_W'(b2_start) * MUL_W'(page_bytes);
  assign prod_size = MUL_W'(b2_pages) * MUL_W'(page_bytes);

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_trail   <= emit_trail;
      b2_start   <= emit_start;
      b2_pages   <= emit_pages;
      b3_trail   <= b2_trail;
      b3_off     <= prod_off[pcdrc_pkg::OFF_W-1:0];
      b3_prod    <= prod_size[pcdrc_pkg::SIZE_W-1:0];
      out_offset <= b3_off;
      out_size   <= b3_trail ? region_bytes - pcdrc_pkg::SIZE_W'(b3_off) : b3_prod;
    end
  end

  assign result.valid      = out_valid;
  assign result.run_offset = out_offset;
  assign result.run_len    = out_size;

  a_init_closes_run: assert property (@(posedge clk) disable iff (rst)
    (adv && b1_valid && b1.cmd == pcdrc_pkg::CMD_INIT) |=> !run_open)
    else $error("init word left a run open");

  a_emit_closes_run: assert property (@(posedge clk) disable iff (rst)
    (adv && b1_valid && emit) |=> (!run_open && b2_valid))
    else $error("emitted run not closed or result lost");

  a_fwd_has_word: assert property (@(posedge clk) disable iff (rst)
    fwd |-> b1_valid)
    else $error("bypass set with no word in execute");

endmodule

// ===== sv/page_checksum_dirty_range_coalescer_top.sv =====
// Results pass the multiply, size and output registers after the scan word closing their run.
// Throughput: one word per cycle while results are taken, one table read-modify-write each.
// A held result stalls the back end; the front stage and a two-word queue keep taking words.
// Reset (rst, synchronous) clears runs and restores register defaults; the checksum table
// is not cleared and a page must be written by init or scan before it is scanned.
module page_checksum_dirty_range_coalescer_top #(
  parameter int MAX_PAGES = pcdrc_pkg::MAX_PAGES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  pcdrc_item_if.sink      item,
  pcdrc_cfg_if.sink       cfg,
  pcdrc_result_if.source  result
);

  logic [pcdrc_pkg::PB_W-1:0]  page_bytes;
  logic [pcdrc_pkg::RB_W-1:0]  region_bytes;
  logic [pcdrc_pkg::PC_W-1:0]  page_count;

  pcdrc_pkg::entry_t           f_ent;
  logic                        f_valid;
  logic                        f_ready;
  pcdrc_pkg::entry_t           q_head;
  logic                        q_valid;
  logic                        q_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes   <= pcdrc_pkg::PAGE_BYTES_RST;
      region_bytes <= pcdrc_pkg::REGION_BYTES_RST;
      page_count   <= pcdrc_pkg::PAGE_COUNT_RST;
    end else if (cfg.valid) begin
      unique case (pcdrc_pkg::cfg_reg_t'(cfg.index))
        pcdrc_pkg::CFG_PAGE_BYTES:   page_bytes   <= cfg.data[pcdrc_pkg::PB_W-1:0];
        pcdrc_pkg::CFG_REGION_BYTES: region_bytes <= cfg.data[pcdrc_pkg::RB_W-1:0];
        pcdrc_pkg::CFG_PAGE_COUNT:   page_count   <= cfg.data[pcdrc_pkg::PC_W-1:0];
        default: begin
          page_count <= page_count;
        end
      endcase
    end
  end

  pcdrc_front #(.MAX_PAGES(MAX_PAGES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .page_count (page_count),
    .ent        (f_ent),
    .ent_valid  (f_valid),
    .ent_ready  (f_ready)
  );

  pcdrc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (f_ent),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop)
  );

  pcdrc_back #(.MAX_PAGES(MAX_PAGES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .head_valid   (q_valid),
    .pop          (q_pop),
    .page_bytes   (page_bytes),
    .region_bytes (region_bytes),
    .result       (result)
  );

endmodule
